FILE: src/gss_pkg.sv
package gss_pkg;

  // Default sizing of the set.
  localparam int SLOTS_DEF   = 1024;
  localparam int VALUE_W_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int FUNC_W   = 2;
  localparam int IDX_FW   = 12;
  localparam int GEN_W    = 16;
  localparam int LIFE_W   = 32;
  localparam int SLOT_FW  = 10;
  localparam int STATUS_W = 3;
  localparam int OWNER_FW = 10;
  localparam int COUNT_FW = 11;

  // Packed word widths, rounded up to whole bytes.
  localparam int IN_W  = 72;
  localparam int OUT_W = 72;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;   // write one generation entry of the clearing pass
    logic take;     // input word accepted: latch it and issue memory reads
    logic commit;   // execute the request: memory writes and result register
  } gss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last; // clearing pass is at its last entry
  } gss_sts_t;

endpackage

FILE: src/gss_ctrl.sv
module gss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                out_tready,
  input  gss_pkg::gss_sts_t   sts,
  output logic                in_tready,
  output logic                out_tvalid,
  output gss_pkg::gss_cmd_t   cmd
);

  gss_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gss_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      gss_pkg::S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = gss_pkg::S_IDLE;
        end
      end
      gss_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = gss_pkg::S_EXEC;
        end
      end
      gss_pkg::S_EXEC: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = gss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gss_pkg::S_CLEAR;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: src/gss_dpath.sv
module gss_dpath #(
  parameter int SLOTS       = gss_pkg::SLOTS_DEF,
  parameter int VALUE_WIDTH = gss_pkg::VALUE_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gss_pkg::gss_cmd_t          cmd,
  output gss_pkg::gss_sts_t          sts,
  input  logic [gss_pkg::IN_W-1:0]   in_word,
  output logic [gss_pkg::OUT_W-1:0]  out_word
);

  localparam int          IDX_W  = $clog2(SLOTS);
  localparam int          CNT_W  = $clog2(SLOTS + 1);
  localparam logic [31:0] SLOTS_U = 32'(SLOTS);

  // Memories.
  logic [16:0]            sgen_mem  [SLOTS];
  logic [IDX_W-1:0]       sslot_mem [SLOTS];
  logic [VALUE_WIDTH-1:0] life_mem  [SLOTS];
  logic [IDX_W-1:0]       owner_mem [SLOTS];

  // Input word fields.
  logic [gss_pkg::FUNC_W-1:0]  in_func;
  logic [gss_pkg::IDX_FW-1:0]  in_idx;
  logic [gss_pkg::GEN_W-1:0]   in_gen;
  logic [gss_pkg::LIFE_W-1:0]  in_life;
  logic [gss_pkg::SLOT_FW-1:0] in_slot;

  assign in_func = in_word[1:0];
  assign in_idx  = in_word[13:2];
  assign in_gen  = in_word[29:14];
  assign in_life = in_word[61:30];
  assign in_slot = in_word[71:62];

  // Latched request and registered memory reads.
  gss_pkg::func_t              func_r;
  logic [gss_pkg::IDX_FW-1:0]  idx_r;
  logic [gss_pkg::GEN_W-1:0]   gen_r;
  logic [gss_pkg::LIFE_W-1:0]  life_r;
  logic [gss_pkg::SLOT_FW-1:0] slot_r;
  logic [16:0]                 gen_rd_r;
  logic [IDX_W-1:0]            sslot_rd_r;
  logic [VALUE_WIDTH-1:0]      life_rd_r;
  logic [IDX_W-1:0]            owner_rd_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] clr_cnt_r;

  // Read addresses at accept time.
  logic [31:0]      in_idx32, in_slot32, last_in32, rd_sel32;
  logic [IDX_W-1:0] idx_addr, rd_addr;

  always_comb begin
    in_idx32  = 32'(in_idx);
    in_slot32 = 32'(in_slot);
    last_in32 = 32'(count_r) - 32'd1;
    rd_sel32  = (gss_pkg::func_t'(in_func) == gss_pkg::FN_READ) ? in_slot32 : last_in32;
    idx_addr  = in_idx32[IDX_W-1:0];
    rd_addr   = rd_sel32[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= gss_pkg::func_t'(in_func);
      idx_r  <= in_idx;
      gen_r  <= in_gen;
      life_r <= in_life;
      slot_r <= in_slot;
    end
  end

  // Request evaluation on the latched word.
  logic [31:0]      idx32, cnt32, s32, slot32, last32, fslot32, own32, cnt_out32;
  logic [IDX_W-1:0] idx_a, cnt_a, s_a;
  logic             idx_ok, key_hit, live, add_ok, rem_ok, move;
  gss_pkg::status_t st;
  logic [63:0]      life_x, life_z;
  logic [31:0]      lval;

  always_comb begin
    idx32   = 32'(idx_r);
    cnt32   = 32'(count_r);
    s32     = 32'(sslot_rd_r);
    slot32  = 32'(slot_r);
    last32  = cnt32 - 32'd1;
    idx_a   = idx32[IDX_W-1:0];
    cnt_a   = cnt32[IDX_W-1:0];
    s_a     = sslot_rd_r;
    idx_ok  = idx32 < SLOTS_U;
    key_hit = gen_rd_r[16] && (gen_rd_r[15:0] == gen_r);
    live    = key_hit && (s32 < cnt32);

    // Stored value read back sign extended from its top bit.
    life_x = {64{life_rd_r[VALUE_WIDTH-1]}};
    life_x[VALUE_WIDTH-1:0] = life_rd_r;
    life_z = 64'(life_r);

    st      = gss_pkg::ST_OK;
    fslot32 = '0;
    own32   = '0;
    lval    = '0;
    add_ok  = 1'b0;
    rem_ok  = 1'b0;
    if (func_r == gss_pkg::FN_READ) begin
      if ((slot32 < cnt32) && (slot32 < SLOTS_U)) begin
        lval  = life_x[31:0];
        own32 = 32'(owner_rd_r);
      end else begin
        st = gss_pkg::ST_NOT_FOUND;
      end
    end else if (!idx_ok) begin
      st = gss_pkg::ST_BAD_INDEX;
    end else if (func_r == gss_pkg::FN_ADD) begin
      if (key_hit) begin
        st = gss_pkg::ST_PRESENT;
      end else if (cnt32 >= SLOTS_U) begin
        st = gss_pkg::ST_FULL;
      end else begin
        add_ok  = 1'b1;
        fslot32 = cnt32;
      end
    end else if (!live) begin
      st = gss_pkg::ST_NOT_FOUND;
    end else if (func_r == gss_pkg::FN_LOOKUP) begin
      fslot32 = s32;
    end else begin
      rem_ok  = 1'b1;
      fslot32 = s32;
    end

    // Remove of an inner slot pulls the last dense entry down into it.
    move = rem_ok && (s32 < last32);

    if (add_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
    cnt_out32 = 32'(count_nxt);
  end

  // Write ports, one per memory.
  logic                   sg_we, ss_we, lf_we, ow_we;
  logic [IDX_W-1:0]       sg_wa, ss_wa, lf_wa, ow_wa;
  logic [16:0]            sg_wd;
  logic [IDX_W-1:0]       ss_wd, ow_wd;
  logic [VALUE_WIDTH-1:0] lf_wd;

  always_comb begin
    sg_we = cmd.clr_we || (cmd.commit && (add_ok || rem_ok));
    sg_wa = cmd.clr_we ? clr_cnt_r : idx_a;
    sg_wd = (!cmd.clr_we && add_ok) ? {1'b1, gen_r} : 17'd0;

    ss_we = cmd.commit && (add_ok || move);
    ss_wa = add_ok ? idx_a : owner_rd_r;
    ss_wd = add_ok ? cnt_a : s_a;

    lf_we = cmd.commit && (add_ok || move);
    lf_wa = add_ok ? cnt_a : s_a;
    lf_wd = add_ok ? life_z[VALUE_WIDTH-1:0] : life_rd_r;

    ow_we = cmd.commit && (add_ok || move);
    ow_wa = add_ok ? cnt_a : s_a;
    ow_wd = add_ok ? idx_a : owner_rd_r;
  end

  always_ff @(posedge clk) begin
    if (sg_we) begin
      sgen_mem[sg_wa] <= sg_wd;
    end
    if (cmd.take) begin
      gen_rd_r <= sgen_mem[idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ss_we) begin
      sslot_mem[ss_wa] <= ss_wd;
    end
    if (cmd.take) begin
      sslot_rd_r <= sslot_mem[idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lf_we) begin
      life_mem[lf_wa] <= lf_wd;
    end
    if (cmd.take) begin
      life_rd_r <= life_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ow_we) begin
      owner_mem[ow_wa] <= ow_wd;
    end
    if (cmd.take) begin
      owner_rd_r <= owner_mem[rd_addr];
    end
  end

  // Entry count and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == IDX_W'(SLOTS - 1));

  // Result register.
  logic [gss_pkg::STATUS_W-1:0] out_status_r;
  logic [gss_pkg::SLOT_FW-1:0]  out_fslot_r;
  logic [gss_pkg::LIFE_W-1:0]   out_life_r;
  logic [gss_pkg::OWNER_FW-1:0] out_owner_r;
  logic [gss_pkg::COUNT_FW-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= st;
      out_fslot_r  <= fslot32[gss_pkg::SLOT_FW-1:0];
      out_life_r   <= lval;
      out_owner_r  <= own32[gss_pkg::OWNER_FW-1:0];
      out_count_r  <= cnt_out32[gss_pkg::COUNT_FW-1:0];
    end
  end

  assign out_word = {6'd0, out_count_r, out_owner_r, out_life_r, out_fslot_r, out_status_r};

endmodule

FILE: src/generational_sparse_set.sv
// Channel  Side    Word fields, lowest bit first
// in_      slave   func[1:0] entity_index[13:2] generation[29:14] life[61:30] slot[71:62]
// out_     master  status[2:0] found_slot[12:3] life_value[44:13] owner_index[54:45] count[65:55]
//
// A request has an accept cycle, which reads the memories into their output registers,
// and an execute cycle, which evaluates the request and commits its writes and result;
// no new word is taken until the execute cycle has committed. After reset the block sweeps the
// generation map to invalid, one entry per cycle, with in_tready low.
// A result waiting on out_tready does not block the next accept, but the execute cycle
// then holds until the result register is taken.
module generational_sparse_set #(
  parameter int SLOTS       = gss_pkg::SLOTS_DEF,
  parameter int VALUE_WIDTH = gss_pkg::VALUE_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func, entity_index, generation, life, slot
  input  logic [gss_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status, found_slot, life_value, owner_index, count, zero pad
  output logic [gss_pkg::OUT_W-1:0] out_tdata
);

  // Command and status between the sequencer and the datapath.
  gss_pkg::gss_cmd_t cmd;
  gss_pkg::gss_sts_t sts;

  gss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  gss_dpath #(
    .SLOTS       (SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_word  (in_tdata),
    .out_word (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // A committed request always presents its result in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed request did not raise out_tvalid");

  // An accepted word is followed by its execute cycle, so no second accept.
  a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !in_tready)
    else $error("input accepted again before execute");

  // Accept and commit never coincide, and nothing is accepted while clearing.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.commit) && !(cmd.clr_we && in_tready))
    else $error("overlapping datapath commands");

  // Commit only when the result register can take the new word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = gss_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT = 60000;

  typedef struct {
    gss_pkg::func_t op;
    logic [11:0]    idx;
    logic [15:0]    gen;
    logic [31:0]    life;
    logic [9:0]     slot;
  } set_req_t;

  typedef struct {
    gss_pkg::status_t status;
    logic [9:0]       found_slot;
    logic [31:0]      life_value;
    logic [9:0]       owner_index;
    logic [10:0]      count;
  } set_result_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [15:0] gen;
  } key_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [gss_pkg::IN_W-1:0] in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [gss_pkg::OUT_W-1:0] out_tdata;

  generational_sparse_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Words still to be sent, results owed by the block, and the keys the
  // stimulus believes are live (only used to shape requests).
  set_req_t    req_queue[$];
  set_result_t due_results[$];
  key_t        issued_keys[$];

  // Mirror of the set's contents.
  logic [31:0] life_mem  [SLOTS];
  logic [9:0]  owner_mem [SLOTS];
  logic [9:0]  slot_map  [SLOTS];
  logic [16:0] gen_map   [SLOTS];
  int          live_count;
  int          peak_count;

  int errors;
  int accepted;
  int checked;
  int status_hits [8];
  int cycle_count;

  // Applies one accepted request word to the mirror and returns the result
  // the block owes for it.
  function automatic set_result_t apply_request(logic [gss_pkg::IN_W-1:0] w);
    gss_pkg::func_t op;
    logic [11:0]    idx;
    logic [15:0]    g;
    logic [31:0]    life;
    logic [9:0]     rs;
    set_result_t    r;
    int             s;
    int             last;
    logic [9:0]     mover;
    bit             hit;
    op   = gss_pkg::func_t'(w[1:0]);
    idx  = w[13:2];
    g    = w[29:14];
    life = w[61:30];
    rs   = w[71:62];
    r.status      = gss_pkg::ST_OK;
    r.found_slot  = '0;
    r.life_value  = '0;
    r.owner_index = '0;
    hit = 1'b0;
    s   = 0;
    if (idx < SLOTS && gen_map[idx[9:0]] == {1'b1, g} && slot_map[idx[9:0]] < live_count) begin
      hit = 1'b1;
      s   = slot_map[idx[9:0]];
    end
    if (op == gss_pkg::FN_READ) begin
      if (rs < live_count) begin
        r.life_value  = life_mem[rs];
        r.owner_index = owner_mem[rs];
      end else begin
        r.status = gss_pkg::ST_NOT_FOUND;
      end
    end else if (idx >= SLOTS) begin
      r.status = gss_pkg::ST_BAD_INDEX;
    end else if (op == gss_pkg::FN_ADD) begin
      if (gen_map[idx[9:0]] == {1'b1, g}) begin
        r.status = gss_pkg::ST_PRESENT;
      end else if (live_count >= SLOTS) begin
        r.status = gss_pkg::ST_FULL;
      end else begin
        s = live_count;
        life_mem[s]         = life;
        slot_map[idx[9:0]]  = 10'(s);
        gen_map[idx[9:0]]   = {1'b1, g};
        owner_mem[s]        = idx[9:0];
        live_count++;
        r.found_slot = 10'(s);
      end
    end else if (!hit) begin
      r.status = gss_pkg::ST_NOT_FOUND;
    end else if (op == gss_pkg::FN_LOOKUP) begin
      r.found_slot = 10'(s);
    end else begin
      // Remove: the last dense entry fills the hole to keep the array packed.
      last = live_count - 1;
      if (s < last) begin
        mover            = owner_mem[last];
        life_mem[s]      = life_mem[last];
        slot_map[mover]  = 10'(s);
        owner_mem[s]     = mover;
      end
      slot_map[idx[9:0]] = '0;
      gen_map[idx[9:0]]  = '0;
      live_count = last;
      r.found_slot = 10'(s);
    end
    if (live_count > peak_count) peak_count = live_count;
    r.count = live_count[10:0];
    return r;
  endfunction

  task automatic push_req(input gss_pkg::func_t op, input logic [11:0] idx,
                          input logic [15:0] g, input logic [31:0] life,
                          input logic [9:0] slot);
    set_req_t q;
    q.op   = op;
    q.idx  = idx;
    q.gen  = g;
    q.life = life;
    q.slot = slot;
    req_queue.push_back(q);
  endtask

  // Mostly well-formed traffic on keys that were added earlier, with some
  // stale generations, out-of-range indexes and random reads mixed in.
  task automatic random_traffic(input int n);
    int          pick;
    int          sub;
    int          j;
    key_t        k;
    logic [11:0] idx;
    logic [15:0] g;
    logic [9:0]  rslot;
    repeat (n) begin
      pick = int'($urandom_range(0, 99));
      sub  = int'($urandom_range(0, 9));
      j    = (issued_keys.size() > 0) ? int'($urandom_range(0, issued_keys.size() - 1)) : 0;
      if (pick < 38) begin
        if (sub < 7 || issued_keys.size() == 0) begin
          idx = 12'($urandom_range(0, SLOTS - 1));
          g   = 16'($urandom_range(0, 65535));
          issued_keys.push_back({idx, g});
        end else if (sub < 8) begin
          k   = issued_keys[j];
          idx = k.idx;
          g   = k.gen;
        end else if (sub < 9) begin
          // Same entity, next generation: repoints the map and orphans the old entry.
          k   = issued_keys[j];
          idx = k.idx;
          g   = k.gen + 16'd1;
          issued_keys.push_back({idx, g});
        end else begin
          idx = 12'($urandom_range(SLOTS, 4095));
          g   = 16'($urandom_range(0, 65535));
        end
        push_req(gss_pkg::FN_ADD, idx, g, $urandom, 10'($urandom_range(0, 1023)));
      end else if (pick < 82) begin
        if (sub < 8 && issued_keys.size() > 0) begin
          k = issued_keys[j];
          if (pick < 65) issued_keys.delete(j);
          idx = k.idx;
          g   = k.gen;
        end else if (sub < 9) begin
          idx = 12'($urandom_range(0, SLOTS - 1));
          g   = 16'($urandom_range(0, 65535));
        end else begin
          idx = 12'($urandom_range(SLOTS, 4095));
          g   = 16'($urandom_range(0, 65535));
        end
        push_req((pick < 65) ? gss_pkg::FN_REMOVE : gss_pkg::FN_LOOKUP, idx, g, $urandom,
                 10'($urandom_range(0, 1023)));
      end else begin
        rslot = (sub == 0) ? 10'($urandom_range(0, 1023))
                           : 10'($urandom_range(0, issued_keys.size() + 3));
        push_req(gss_pkg::FN_READ, 12'($urandom_range(0, 4095)),
                 16'($urandom_range(0, 65535)), $urandom, rslot);
      end
    end
  endtask

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_tvalid || due_results.size() != 0);
  endtask

  // Request driver: one word in flight, a random gap before each next word,
  // with occasional stretches of back-to-back traffic.
  set_req_t nxt;
  int       in_gap;
  bit       in_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_request(in_tdata));
        accepted++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (req_queue.size() > 0) begin
          nxt = req_queue.pop_front();
          in_tdata  <= {nxt.slot, nxt.life, nxt.gen, nxt.idx, nxt.op};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : int'($urandom_range(0, 4));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word against the oldest owed result and
  // stalls the result channel at random.
  set_result_t want;
  int          out_gap;
  bit          out_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result word 0x%0h arrived with no request outstanding", out_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (out_tdata[2:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[12:3] !== want.found_slot) begin
            $error("found_slot: expected %0d, got %0d", want.found_slot, out_tdata[12:3]);
            errors++;
          end
          if (out_tdata[44:13] !== want.life_value) begin
            $error("life_value: expected 0x%08h, got 0x%08h", want.life_value,
                   out_tdata[44:13]);
            errors++;
          end
          if (out_tdata[54:45] !== want.owner_index) begin
            $error("owner_index: expected %0d, got %0d", want.owner_index,
                   out_tdata[54:45]);
            errors++;
          end
          if (out_tdata[65:55] !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_tdata[65:55]);
            errors++;
          end
        end
        status_hits[out_tdata[2:0]]++;
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_gap = out_calm ? 0 : int'($urandom_range(0, 4));
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[generational_sparse_set] ERROR");
      $finish;
    end
  end

  initial begin
    int   i;
    key_t k;
    for (i = 0; i < SLOTS; i++) begin
      life_mem[i]  = '0;
      owner_mem[i] = '0;
      slot_map[i]  = '0;
      gen_map[i]   = '0;
    end
    live_count = 0;
    peak_count = 0;

    // Directed opening: empty set, field extremes, duplicates, bad indexes,
    // a generation bump on a live entity, and removes that move the tail.
    push_req(gss_pkg::FN_READ,   12'd0,    16'd0,    32'd0,        10'd0);
    push_req(gss_pkg::FN_LOOKUP, 12'd5,    16'd7,    32'd0,        10'd0);
    push_req(gss_pkg::FN_REMOVE, 12'd5,    16'd7,    32'd0,        10'd0);
    push_req(gss_pkg::FN_ADD,    12'd0,    16'd0,    32'h80000000, 10'd0);
    push_req(gss_pkg::FN_ADD,    12'd1023, 16'hFFFF, 32'h7FFFFFFF, 10'd1023);
    push_req(gss_pkg::FN_ADD,    12'd0,    16'd0,    32'd0,        10'd0);
    push_req(gss_pkg::FN_ADD,    12'd4095, 16'd0,    32'hFFFFFFFF, 10'd1023);
    push_req(gss_pkg::FN_LOOKUP, 12'd1024, 16'd0,    32'd0,        10'd0);
    push_req(gss_pkg::FN_REMOVE, 12'd4095, 16'hFFFF, 32'd0,        10'd0);
    push_req(gss_pkg::FN_ADD,    12'd0,    16'd1,    32'hFFFFFFFF, 10'd0);
    push_req(gss_pkg::FN_LOOKUP, 12'd0,    16'd0,    32'd0,        10'd0);
    push_req(gss_pkg::FN_LOOKUP, 12'd0,    16'd1,    32'd0,        10'd0);
    push_req(gss_pkg::FN_READ,   12'd0,    16'd0,    32'd0,        10'd0);
    push_req(gss_pkg::FN_READ,   12'd4095, 16'hFFFF, 32'hFFFFFFFF, 10'd1);
    push_req(gss_pkg::FN_READ,   12'd0,    16'd0,    32'd0,        10'd1023);
    push_req(gss_pkg::FN_ADD,    12'd7,    16'd3,    32'd0,        10'd0);
    push_req(gss_pkg::FN_REMOVE, 12'd1023, 16'hFFFF, 32'd0,        10'd0);
    push_req(gss_pkg::FN_LOOKUP, 12'd7,    16'd3,    32'd0,        10'd0);
    push_req(gss_pkg::FN_READ,   12'd0,    16'd0,    32'd0,        10'd1);
    push_req(gss_pkg::FN_REMOVE, 12'd1023, 16'hFFFF, 32'd0,        10'd0);
    push_req(gss_pkg::FN_REMOVE, 12'd0,    16'd1,    32'd0,        10'd0);
    push_req(gss_pkg::FN_READ,   12'd0,    16'd0,    32'd0,        10'd2);

    random_traffic(500);
    wait_drained();

    // Full cycle on one remembered key: look it up, remove it, look it up again, add it back twice.
    if (issued_keys.size() > 0) begin
      k = issued_keys[0];
      push_req(gss_pkg::FN_LOOKUP, k.idx, k.gen, 32'd0,     10'd0);
      push_req(gss_pkg::FN_REMOVE, k.idx, k.gen, 32'd0,     10'd0);
      push_req(gss_pkg::FN_LOOKUP, k.idx, k.gen, 32'd0,     10'd0);
      push_req(gss_pkg::FN_ADD,    k.idx, k.gen, $urandom,  10'd0);
      push_req(gss_pkg::FN_ADD,    k.idx, k.gen, $urandom,  10'd0);
    end
    random_traffic(75);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d request words and checked %0d results; peak occupancy %0d of %0d.",
             accepted, checked, peak_count, SLOTS);
    $display("Outcomes ok/bad-index/present/full/not-found: %0d/%0d/%0d/%0d/%0d.",
             status_hits[gss_pkg::ST_OK], status_hits[gss_pkg::ST_BAD_INDEX],
             status_hits[gss_pkg::ST_PRESENT], status_hits[gss_pkg::ST_FULL],
             status_hits[gss_pkg::ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("[generational_sparse_set] OK");
    end else begin
      $display("[generational_sparse_set] ERROR");
    end
    $finish;
  end

endmodule
